### src/advective_outflow_bc_coeffs_defines.svh
// Assertion macros shared by the advective outflow boundary coefficient block.
`ifndef ADVECTIVE_OUTFLOW_BC_COEFFS_DEFINES_SVH
`define ADVECTIVE_OUTFLOW_BC_COEFFS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AOBC_ASSERT(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AOBC_ASSERT_NXT(lbl, ck, rn, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (pre) |=> (post)) \
    else $error(msg);

`endif

### src/aobc_pkg.sv
// Shared constants for the advective outflow boundary coefficient block.
package aobc_pkg;

  localparam int FRAC = 16;                         // Q16.16 fraction bits
  localparam int VW   = 47;                         // internal unsigned value width

  localparam logic [VW-1:0] CAP        = {VW{1'b1}};
  localparam logic [VW-1:0] ONE_Q      = VW'(65536);
  localparam logic [VW-1:0] ONE_HALF_Q = VW'(98304);

  localparam logic [16:0] VF_ONE = 17'h1_0000;

  // Backward base is old + floor((old - older)/3). The difference is offset by
  // 3*2^31 to stay nonnegative, divided by a reciprocal multiply (ceil(2^35/3),
  // then >> 35) and the 2^31 left by the offset is taken off again.
  localparam logic [33:0] B3_OFS   = 34'h1_8000_0000;
  localparam logic [33:0] B3_RECIP = 34'h2_AAAA_AAAB;
  localparam logic [32:0] B3_BIAS  = 33'h0_8000_0000;

  localparam int CFG_AW = 5;

  localparam logic [2:0] REG_TIME_STEP        = 3'd0;
  localparam logic [2:0] REG_TIME_SCHEME      = 3'd1;
  localparam logic [2:0] REG_RELAX_LENGTH     = 3'd2;
  localparam logic [2:0] REG_FAR_VALUE        = 3'd3;
  localparam logic [2:0] REG_INLET_OUTLET_ON  = 3'd4;
  localparam logic [2:0] REG_SUPERCRITICAL_ON = 3'd5;
  localparam logic [2:0] REG_FLUX_IS_MASS     = 3'd6;

  localparam logic [1:0] SCH_EULER    = 2'd0;
  localparam logic [1:0] SCH_CRANK    = 2'd1;
  localparam logic [1:0] SCH_BACKWARD = 2'd2;
  localparam logic [1:0] SCH_STEADY   = 2'd3;

  localparam logic [30:0] TIME_STEP_RST = 31'd65536;

endpackage

### src/aobc_div.sv
// Pipelined restoring divider: one quotient bit per stage, payload carried alongside.
`include "advective_outflow_bc_coeffs_defines.svh"

module aobc_div #(
  parameter int NW = 63,
  parameter int DW = 62,
  parameter int QW = 47,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [PW-1:0] pay_o
);

  localparam int HW = NW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;
  logic          ovf_in;

  logic          vld_r [QW+1];
  logic          ovf_r [QW+1];
  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] qlo_r [QW+1];
  logic [PW-1:0] pay_r [QW+1];

  // Quotient would not fit in QW bits (also covers a zero divisor).
  assign hi_ext  = CW'(num_i[NW-1:QW]);
  assign den_ext = CW'(den_i);
  assign ovf_in  = hi_ext >= den_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= ovf_in;
      rem_r[0] <= ovf_in ? '0 : hi_ext[DW-1:0];
      den_r[0] <= den_i;
      qlo_r[0] <= num_i[QW-1:0];
      pay_r[0] <= pay_i;
    end
  end

  // Low dividend bits shift out at the top while quotient bits shift in below.
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    assign trial   = {rem_r[i], qlo_r[i][QW-1]};
    assign diff    = trial - {1'b0, den_r[i]};
    assign ge      = trial >= {1'b0, den_r[i]};
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[i+1] <= ovf_r[i];
        rem_r[i+1] <= rem_nxt;
        den_r[i+1] <= den_r[i];
        qlo_r[i+1] <= {qlo_r[i][QW-2:0], ge};
        pay_r[i+1] <= pay_r[i];
      end
    end
  end

  assign vld_o = vld_r[QW];
  assign quo_o = qlo_r[QW];
  assign ovf_o = ovf_r[QW];
  assign pay_o = pay_r[QW];

  `AOBC_ASSERT(a_rem_below_den, clk, rst_n, vld_r[QW] && !ovf_r[QW], rem_r[QW] < den_r[QW], "remainder not below divisor")
  `AOBC_ASSERT(a_zero_den_ovf, clk, rst_n, vld_r[0] && den_r[0] == '0, ovf_r[0], "zero divisor not flagged")
  `AOBC_ASSERT_NXT(a_hold_on_stall, clk, rst_n, !en, $stable(qlo_r[QW]), "quotient moved while stalled")

endmodule

### src/aobc_qmul.sv
// Two-stage saturating Q16.16 multiplier, operand a split in two halves.
module aobc_qmul #(
  parameter int AW = 47,
  parameter int BW = 31,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic [PW-1:0] pay_i,
  output logic          vld_o,
  output logic [AW-1:0] p_o,
  output logic [PW-1:0] pay_o
);

  localparam int LW = (AW + 1) / 2;
  localparam int HW = AW - LW;
  localparam int SW = AW + BW;
  localparam int RW = SW - aobc_pkg::FRAC;

  logic             vld1_r;
  logic             vld2_r;
  logic [LW+BW-1:0] pl_r;
  logic [HW+BW-1:0] ph_r;
  logic [PW-1:0]    pay1_r;
  logic [PW-1:0]    pay2_r;
  logic [SW-1:0]    sum;
  logic [RW-1:0]    shr;
  logic [AW-1:0]    p_nxt;
  logic [AW-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r   <= a_i[LW-1:0] * b_i;
      ph_r   <= a_i[AW-1:LW] * b_i;
      pay1_r <= pay_i;
      p_r    <= p_nxt;
      pay2_r <= pay1_r;
    end
  end

  assign sum   = {ph_r, {LW{1'b0}}} + SW'(pl_r);
  assign shr   = sum[SW-1:aobc_pkg::FRAC];
  // Anything above the value width saturates to all ones.
  assign p_nxt = (|shr[RW-1:AW]) ? {AW{1'b1}} : shr[AW-1:0];

  assign vld_o = vld2_r;
  assign p_o   = p_r;
  assign pay_o = pay2_r;

endmodule

### src/advective_outflow_bc_coeffs.sv
// Advective outflow boundary: per-face mixed-condition reference value and value fraction.
// Each face arrives as one input transfer and yields one result transfer, in order. The
// block is a fixed pipeline that takes a face on every clock unless stalled; its depth is
// set by five bit-serial divider pipelines (three of 47 quotient bits in series, then two of
// 17 side by side) and two two-stage multipliers in series.
// The pipeline stalls as a whole only when its last stage holds a result and the output
// register is full and not taken.
// Registers are written through the APB port and must stay unchanged while faces are in
// flight. No memories, no clearing pass after reset.
`include "advective_outflow_bc_coeffs_defines.svh"

module advective_outflow_bc_coeffs (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // face_flux[31:0], face_area[62:32], face_density[93:63], delta_coeff[124:94],
  // old_value[156:125], older_value[188:157], prev_iter_value[220:189], zero pad
  input  logic [223:0] in_tdata,
  // is_supercritical[0]
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // reference_value[31:0], value_fraction[48:32], zero pad
  output logic [55:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [aobc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int VW = aobc_pkg::VW;

  typedef struct packed {
    logic [32:0] nb;
    logic [30:0] dc;
    logic        fpos;
    logic        outflow;
    logic        supc;
  } p1_t;

  typedef struct packed {
    logic [VW-1:0] w;
    logic [32:0]   base;
    logic [30:0]   dc;
    logic          outflow;
    logic          supc;
  } p2_t;

  typedef struct packed {
    logic [VW-1:0] w;
    logic [VW-1:0] m1;
    logic [32:0]   base;
    logic [30:0]   dc;
    logic          outflow;
    logic          supc;
  } p3_t;

  typedef struct packed {
    logic [VW-1:0] wdt;
    logic [32:0]   base;
    logic          pnz;
    logic          outflow;
    logic          supc;
  } p4_t;

  typedef struct packed {
    logic [VW-1:0] alpha;
    logic [32:0]   base;
    logic          outflow;
    logic          supc;
  } p5_t;

  typedef struct packed {
    logic [32:0] base;
    logic        outflow;
    logic        supc;
  } p6_t;

  // Configuration registers
  logic [30:0] time_step_r;
  logic [1:0]  time_scheme_r;
  logic [30:0] relax_length_r;
  logic [31:0] far_value_r;
  logic        inlet_outlet_on_r;
  logic        supercritical_on_r;
  logic        flux_is_mass_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r        <= aobc_pkg::TIME_STEP_RST;
      time_scheme_r      <= aobc_pkg::SCH_EULER;
      relax_length_r     <= '0;
      far_value_r        <= '0;
      inlet_outlet_on_r  <= 1'b0;
      supercritical_on_r <= 1'b0;
      flux_is_mass_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        aobc_pkg::REG_TIME_STEP:        time_step_r        <= cfg_pwdata[30:0];
        aobc_pkg::REG_TIME_SCHEME:      time_scheme_r      <= cfg_pwdata[1:0];
        aobc_pkg::REG_RELAX_LENGTH:     relax_length_r     <= cfg_pwdata[30:0];
        aobc_pkg::REG_FAR_VALUE:        far_value_r        <= cfg_pwdata;
        aobc_pkg::REG_INLET_OUTLET_ON:  inlet_outlet_on_r  <= cfg_pwdata[0];
        aobc_pkg::REG_SUPERCRITICAL_ON: supercritical_on_r <= cfg_pwdata[0];
        aobc_pkg::REG_FLUX_IS_MASS:     flux_is_mass_r     <= cfg_pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      aobc_pkg::REG_TIME_STEP:        cfg_prdata = {1'b0, time_step_r};
      aobc_pkg::REG_TIME_SCHEME:      cfg_prdata = {30'b0, time_scheme_r};
      aobc_pkg::REG_RELAX_LENGTH:     cfg_prdata = {1'b0, relax_length_r};
      aobc_pkg::REG_FAR_VALUE:        cfg_prdata = far_value_r;
      aobc_pkg::REG_INLET_OUTLET_ON:  cfg_prdata = {31'b0, inlet_outlet_on_r};
      aobc_pkg::REG_SUPERCRITICAL_ON: cfg_prdata = {31'b0, supercritical_on_r};
      aobc_pkg::REG_FLUX_IS_MASS:     cfg_prdata = {31'b0, flux_is_mass_r};
      default:                        cfg_prdata = '0;
    endcase
  end

  logic is_steady;
  logic is_backward;
  assign is_steady   = time_scheme_r == aobc_pkg::SCH_STEADY;
  assign is_backward = time_scheme_r == aobc_pkg::SCH_BACKWARD;

  // Global advance: hold only when the last stage is full and the output is blocked
  logic en;
  logic f1_vld_r;
  logic out_valid_r;
  assign en        = !f1_vld_r || !out_valid_r || out_tready;
  assign in_tready = en;

  // Input stage: unpack, form the speed division operands and the backward base products
  logic [31:0] flux;
  logic [30:0] area;
  logic [30:0] dens;
  logic [30:0] dcoef;
  logic [31:0] oldv;
  logic [31:0] olderv;
  logic [31:0] previ;
  logic [61:0] area_dens;
  logic [32:0] d_oo;
  logic [33:0] x3;
  p1_t         s1_pay_nxt;

  assign flux   = in_tdata[31:0];
  assign area   = in_tdata[62:32];
  assign dens   = in_tdata[93:63];
  assign dcoef  = in_tdata[124:94];
  assign oldv   = in_tdata[156:125];
  assign olderv = in_tdata[188:157];
  assign previ  = in_tdata[220:189];

  assign area_dens = area * dens;
  assign d_oo      = {oldv[31], oldv} - {olderv[31], olderv};
  assign x3        = {d_oo[32], d_oo} + aobc_pkg::B3_OFS;

  assign s1_pay_nxt.nb      = is_steady ? {previ[31], previ} : {oldv[31], oldv};
  assign s1_pay_nxt.dc      = dcoef;
  assign s1_pay_nxt.fpos    = !flux[31] && (flux != '0);
  assign s1_pay_nxt.outflow = !flux[31];
  assign s1_pay_nxt.supc    = in_tuser[0];

  logic        s1_vld_r;
  logic [62:0] s1_num_r;
  logic [61:0] s1_den_r;
  logic [50:0] s1_b3l_r;
  logic [50:0] s1_b3h_r;
  p1_t         s1_pay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num_r <= flux_is_mass_r ? {flux[30:0], 32'b0} : {16'b0, flux[30:0], 16'b0};
      s1_den_r <= flux_is_mass_r ? area_dens : 62'(area);
      s1_b3l_r <= x3[16:0] * aobc_pkg::B3_RECIP;
      s1_b3h_r <= x3[33:17] * aobc_pkg::B3_RECIP;
      s1_pay_r <= s1_pay_nxt;
    end
  end

  // Backward base: old + floor((old - older)/3)
  logic [67:0] b3_prod;
  logic [32:0] b3_base;
  p1_t         d1_pay_in;

  assign b3_prod = {s1_b3h_r, 17'b0} + 68'(s1_b3l_r);
  assign b3_base = s1_pay_r.nb + b3_prod[67:35] - aobc_pkg::B3_BIAS;

  assign d1_pay_in.nb      = is_backward ? b3_base : s1_pay_r.nb;
  assign d1_pay_in.dc      = s1_pay_r.dc;
  assign d1_pay_in.fpos    = s1_pay_r.fpos;
  assign d1_pay_in.outflow = s1_pay_r.outflow;
  assign d1_pay_in.supc    = s1_pay_r.supc;

  // Wave speed division
  logic          d1_vld;
  logic [VW-1:0] d1_quo;
  logic          d1_ovf;
  p1_t           d1_pay;

  aobc_div #(.NW(63), .DW(62), .QW(VW), .PW($bits(p1_t))) u_div_w (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(s1_vld_r), .num_i(s1_num_r), .den_i(s1_den_r), .pay_i(d1_pay_in),
    .vld_o(d1_vld), .quo_o(d1_quo), .ovf_o(d1_ovf), .pay_o(d1_pay)
  );

  logic [VW-1:0] w_val;
  p2_t           m1_pay_in;

  assign w_val  = !d1_pay.fpos ? '0 : (d1_ovf ? aobc_pkg::CAP : d1_quo);

  assign m1_pay_in.w       = w_val;
  assign m1_pay_in.base    = d1_pay.nb;
  assign m1_pay_in.dc      = d1_pay.dc;
  assign m1_pay_in.outflow = d1_pay.outflow;
  assign m1_pay_in.supc    = d1_pay.supc;

  // w*dt, or w*delta_coeff for the steady scheme
  logic          m1_vld;
  logic [VW-1:0] m1_p;
  p2_t           m1_pay;

  aobc_qmul #(.AW(VW), .BW(31), .PW($bits(p2_t))) u_mul_1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(d1_vld), .a_i(w_val), .b_i(is_steady ? d1_pay.dc : time_step_r),
    .pay_i(m1_pay_in),
    .vld_o(m1_vld), .p_o(m1_p), .pay_o(m1_pay)
  );

  p3_t d2_pay_in;
  assign d2_pay_in.w       = m1_pay.w;
  assign d2_pay_in.m1      = m1_p;
  assign d2_pay_in.base    = m1_pay.base;
  assign d2_pay_in.dc      = m1_pay.dc;
  assign d2_pay_in.outflow = m1_pay.outflow;
  assign d2_pay_in.supc    = m1_pay.supc;

  // Steady scheme formal step: w / (w*delta_coeff)
  logic          d2_vld;
  logic [VW-1:0] d2_quo;
  logic          d2_ovf;
  p3_t           d2_pay;

  aobc_div #(.NW(63), .DW(VW), .QW(VW), .PW($bits(p3_t))) u_div_st (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(m1_vld), .num_i({m1_pay.w, 16'b0}), .den_i(m1_p), .pay_i(d2_pay_in),
    .vld_o(d2_vld), .quo_o(d2_quo), .ovf_o(d2_ovf), .pay_o(d2_pay)
  );

  logic          pnz;
  logic [VW-1:0] wdt_st;
  logic [VW-1:0] wdt_val;
  p4_t           m2_pay_in;

  assign pnz     = d2_pay.m1 != '0;
  assign wdt_st  = pnz ? (d2_ovf ? aobc_pkg::CAP : d2_quo)
                       : ((d2_pay.w != '0) ? aobc_pkg::CAP : '0);
  assign wdt_val = is_steady ? wdt_st : d2_pay.m1;

  assign m2_pay_in.wdt     = wdt_val;
  assign m2_pay_in.base    = d2_pay.base;
  assign m2_pay_in.pnz     = pnz;
  assign m2_pay_in.outflow = d2_pay.outflow;
  assign m2_pay_in.supc    = d2_pay.supc;

  // Courant number wdt*delta_coeff
  logic          m2_vld;
  logic [VW-1:0] m2_p;
  p4_t           m2_pay;

  aobc_qmul #(.AW(VW), .BW(31), .PW($bits(p4_t))) u_mul_2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(d2_vld), .a_i(wdt_val), .b_i(d2_pay.dc), .pay_i(m2_pay_in),
    .vld_o(m2_vld), .p_o(m2_p), .pay_o(m2_pay)
  );

  p5_t d3_pay_in;
  assign d3_pay_in.alpha   = is_steady ? (m2_pay.pnz ? aobc_pkg::ONE_Q : '0) : m2_p;
  assign d3_pay_in.base    = m2_pay.base;
  assign d3_pay_in.outflow = m2_pay.outflow;
  assign d3_pay_in.supc    = m2_pay.supc;

  // Relaxation k = wdt / relax_length
  logic          d3_vld;
  logic [VW-1:0] d3_quo;
  logic          d3_ovf;
  p5_t           d3_pay;

  aobc_div #(.NW(63), .DW(31), .QW(VW), .PW($bits(p5_t))) u_div_k (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(m2_vld), .num_i({m2_pay.wdt, 16'b0}), .den_i(relax_length_r),
    .pay_i(d3_pay_in),
    .vld_o(d3_vld), .quo_o(d3_quo), .ovf_o(d3_ovf), .pay_o(d3_pay)
  );

  logic [VW-1:0] k_val;
  logic [VW-1:0] c_val;
  logic [VW:0]   ck;
  logic [VW+1:0] cak;
  p6_t           d4_pay_in;

  assign k_val = (relax_length_r == '0) ? '0 : (d3_ovf ? aobc_pkg::CAP : d3_quo);
  assign c_val = is_backward ? aobc_pkg::ONE_HALF_Q : aobc_pkg::ONE_Q;
  assign ck    = {1'b0, c_val} + {1'b0, k_val};
  assign cak   = {1'b0, ck} + {2'b0, d3_pay.alpha};

  assign d4_pay_in.base    = d3_pay.base;
  assign d4_pay_in.outflow = d3_pay.outflow;
  assign d4_pay_in.supc    = d3_pay.supc;

  // Blend ratio r = k/(c+k) and value fraction (c+k)/(c+alpha+k), side by side
  logic        d4_vld;
  logic [16:0] d4_quo;
  p6_t         d4_pay;
  logic [16:0] d5_quo;

  aobc_div #(.NW(63), .DW(VW+1), .QW(17), .PW($bits(p6_t))) u_div_r (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(d3_vld), .num_i({k_val, 16'b0}), .den_i(ck), .pay_i(d4_pay_in),
    .vld_o(d4_vld), .quo_o(d4_quo), .ovf_o(), .pay_o(d4_pay)
  );

  aobc_div #(.NW(64), .DW(VW+2), .QW(17), .PW(1)) u_div_vf (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(d3_vld), .num_i({ck, 16'b0}), .den_i(cak), .pay_i(1'b0),
    .vld_o(), .quo_o(d5_quo), .ovf_o(), .pay_o()
  );

  // (far - base) * r
  logic signed [33:0] diff;
  logic signed [51:0] prod_nxt;
  assign diff     = $signed({far_value_r[31], far_value_r}) -
                    $signed({d4_pay.base[32], d4_pay.base});
  assign prod_nxt = diff * $signed({1'b0, d4_quo});

  logic signed [51:0] f1_prod_r;
  logic [32:0]        f1_base_r;
  logic [16:0]        f1_vf_r;
  logic               f1_outflow_r;
  logic               f1_supc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= d4_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_prod_r    <= prod_nxt;
      f1_base_r    <= d4_pay.base;
      f1_vf_r      <= d5_quo;
      f1_outflow_r <= d4_pay.outflow;
      f1_supc_r    <= d4_pay.supc;
    end
  end

  // base + floor(product / 2^16), saturated, then the face overrides
  logic signed [36:0] ref_wide;
  logic [31:0]        ref_sat;
  logic [31:0]        ref_nxt;
  logic [16:0]        vf_nxt;

  assign ref_wide = $signed({{4{f1_base_r[32]}}, f1_base_r}) +
                    $signed({f1_prod_r[51], f1_prod_r[51:16]});

  always_comb begin
    if (ref_wide[36:31] == '0 || ref_wide[36:31] == '1) begin
      ref_sat = ref_wide[31:0];
    end else if (ref_wide[36]) begin
      ref_sat = 32'h8000_0000;
    end else begin
      ref_sat = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    ref_nxt = ref_sat;
    vf_nxt  = f1_vf_r;
    if (supercritical_on_r && f1_supc_r) begin
      ref_nxt = far_value_r;
      vf_nxt  = f1_outflow_r ? '0 : aobc_pkg::VF_ONE;
    end
    if (inlet_outlet_on_r && !f1_outflow_r) begin
      ref_nxt = far_value_r;
      vf_nxt  = aobc_pkg::VF_ONE;
    end
  end

  // Output register
  logic [31:0] out_ref_r;
  logic [16:0] out_vf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid_r || out_tready) && f1_vld_r) begin
      out_ref_r <= ref_nxt;
      out_vf_r  <= vf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_vf_r, out_ref_r};

  `AOBC_ASSERT(a_stall_only_blocked, clk, rst_n, !in_tready, out_valid_r && !out_tready, "input held off without a blocked output")
  `AOBC_ASSERT(a_vf_range, clk, rst_n, out_valid_r, out_vf_r <= aobc_pkg::VF_ONE, "value fraction above one")
  `AOBC_ASSERT(a_no_relax_no_blend, clk, rst_n, d4_vld && relax_length_r == '0, d4_quo == '0, "blend ratio nonzero with relaxation off")

endmodule
